@@ sv/slfs_pkg.sv @@
// Package: shared types, constants and helpers for the LED frame serializer.
`default_nettype none
package slfs_pkg;

  localparam int unsigned MaxLeds = 1024;
  localparam int unsigned IdxW    = $clog2(MaxLeds);

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_WRITE = 3'd1;
  localparam logic [2:0] REQ_READ  = 3'd2;
  localparam logic [2:0] REQ_ADD   = 3'd3;
  localparam logic [2:0] REQ_SUB   = 3'd4;
  localparam logic [2:0] REQ_SCALE = 3'd5;
  localparam logic [2:0] REQ_START = 3'd6;

  localparam logic [2:0] CFG_COLS   = 3'd0;
  localparam logic [2:0] CFG_ROWS   = 3'd1;
  localparam logic [2:0] CFG_CHAIN  = 3'd2;
  localparam logic [2:0] CFG_ZHIGH  = 3'd3;
  localparam logic [2:0] CFG_OHIGH  = 3'd4;
  localparam logic [2:0] CFG_PERIOD = 3'd5;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  pos_x;
    logic [4:0]  pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] amount;
  } in_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       not_black;
    logic       rejected;
  } out_t;

  // One byte of a whole-frame operation.
  function automatic logic [7:0] chan_op(input logic [7:0] b, input logic [2:0] op,
                                         input logic [15:0] amt);
    logic [8:0]  s;
    logic [23:0] p;
    logic [7:0]  r;
    s = {1'b0, b} + {1'b0, amt[7:0]};
    p = b * amt;
    r = b;
    case (op)
      REQ_ADD: r = s[8] ? b : s[7:0];
      REQ_SUB: r = (b >= amt[7:0]) ? b - amt[7:0] : b;
      default: r = (p[23:16] != 8'd0) ? 8'hFF : p[15:8];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/slfs_store.sv @@
// Frame store memory: one write port and one registered read port.
`default_nettype none
module slfs_store (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [slfs_pkg::IdxW-1:0] waddr,
  input  wire logic [23:0]               wdata,
  input  wire logic [slfs_pkg::IdxW-1:0] raddr,
  output logic      [23:0]               rdata
);
  logic [23:0] mem [slfs_pkg::MaxLeds];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/serpentine_led_frame_serializer_unit.sv @@
// Top level: request sequencer, frame store and pulse line serializer.
//
//   channel | direction | handshake
//   req     | in        | req_valid / req_stall
//   res     | out       | res_valid / res_stall
//   cfg     | in        | cfg_we (index, data)
//
// After reset a clearing pass zeroes all 1024 store words, one per cycle.
// Tick items pass through word fetch, then result; read and write first map
// the coordinates, and a read also captures the word. Whole-frame add,
// subtract and scale read and write back each of min(chain_length, 1024)
// words in turn, with one chan_op per byte working on a whole word at once.
// A stalled result holds in its register until taken; the next item may be
// accepted meanwhile, and its result waits in the last state until then.
`default_nettype none
module serpentine_led_frame_serializer_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire slfs_pkg::in_t         req,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output slfs_pkg::out_t             res,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [10:0]           cfg_data
);
  localparam int W = slfs_pkg::IdxW;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MAP   = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_RDW   = 8'b0001_0000,
    S_OPW   = 8'b0010_0000,
    S_FETCH = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  slfs_pkg::in_t item;

  logic [5:0]  cols, rows;
  logic [10:0] chain_length;
  logic [7:0]  zero_high, one_high, period;

  logic [W-1:0] send_index;
  logic [4:0]   bit_index;
  logic [7:0]   tick_count;
  logic         sending;

  logic [W:0]   addr;
  logic [W:0]   clr_count;
  logic         we;
  logic [W-1:0] waddr, raddr;
  logic [23:0]  wdata, rdata;
  logic         rej;
  logic [23:0]  rd_word;

  logic [W:0]   active;
  logic [10:0]  lin;
  logic         lin_over;
  logic         done_go;

  slfs_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign active = (chain_length > 11'(slfs_pkg::MaxLeds)) ?
                  (W+1)'(slfs_pkg::MaxLeds) : chain_length[W:0];
  assign req_stall = (state != S_IDLE);
  // The finished result moves out once the previous beat has left the register.
  assign done_go = (state == S_DONE) && !(res_valid && res_stall);

  // Serpentine index of the latched coordinates.
  always_comb begin
    lin = 11'(cols) * 11'(item.pos_y);
    if (item.pos_y[0]) lin = lin + 11'(cols) - 11'd1 - 11'(item.pos_x);
    else lin = lin + 11'(item.pos_x);
  end

  assign lin_over = (lin >= 11'(slfs_pkg::MaxLeds));

  always_comb begin
    we = 1'b0;
    waddr = addr[W-1:0];
    wdata = 24'd0;
    raddr = addr[W-1:0];
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = clr_count[W-1:0];
      end
      S_MAP: begin
        raddr = lin[W-1:0];
        we = (item.req_type == slfs_pkg::REQ_WRITE) && !rej && !lin_over;
        waddr = lin[W-1:0];
        wdata = {item.green, item.red, item.blue};
      end
      S_OPW: begin
        we = 1'b1;
        wdata = {slfs_pkg::chan_op(rdata[23:16], item.req_type, item.amount),
                 slfs_pkg::chan_op(rdata[15:8], item.req_type, item.amount),
                 slfs_pkg::chan_op(rdata[7:0], item.req_type, item.amount)};
      end
      S_FETCH, S_DONE: raddr = send_index;
      default: ;
    endcase
  end

  logic [7:0] per, high;
  logic       cur_bit;
  always_comb begin
    per = (period < 8'd2) ? 8'd1 : period;
    cur_bit = rdata[5'd23 - bit_index];
    high = cur_bit ? one_high : zero_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= 6'd32; rows <= 6'd32; chain_length <= 11'd1024;
      zero_high <= 8'd6; one_high <= 8'd13; period <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        slfs_pkg::CFG_COLS:   cols <= cfg_data[5:0];
        slfs_pkg::CFG_ROWS:   rows <= cfg_data[5:0];
        slfs_pkg::CFG_CHAIN:  chain_length <= cfg_data;
        slfs_pkg::CFG_ZHIGH:  zero_high <= cfg_data[7:0];
        slfs_pkg::CFG_OHIGH:  one_high <= cfg_data[7:0];
        slfs_pkg::CFG_PERIOD: period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_count <= '0;
      res_valid <= 1'b0;
      sending <= 1'b0;
      send_index <= '0;
      bit_index <= '0;
      tick_count <= '0;
      rej <= 1'b0;
      rd_word <= '0;
      addr <= '0;
    end else begin
      if (done_go) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_count <= clr_count + 1'b1;
          if (clr_count == (W+1)'(slfs_pkg::MaxLeds - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid && !req_stall) begin
            item <= req;
            rej <= 1'b0;
            rd_word <= '0;
            addr <= '0;
            if (req.req_type == slfs_pkg::REQ_TICK || req.req_type == 3'd7) begin
              if (sending) begin
                if (tick_count + 8'd1 >= per) begin
                  tick_count <= '0;
                  if (bit_index == 5'd23) begin
                    bit_index <= '0;
                    if ((W+1)'(send_index) + 1'b1 >= active) begin
                      sending <= 1'b0;
                      send_index <= '0;
                    end else send_index <= send_index + 1'b1;
                  end else bit_index <= bit_index + 1'b1;
                end else tick_count <= tick_count + 8'd1;
              end
              state <= S_FETCH;
            end else if (sending) begin
              rej <= 1'b1;
              state <= S_FETCH;
            end else begin
              case (req.req_type)
                slfs_pkg::REQ_WRITE, slfs_pkg::REQ_READ: begin
                  rej <= ({1'b0, req.pos_x} >= cols) || ({1'b0, req.pos_y} >= rows);
                  state <= S_MAP;
                end
                slfs_pkg::REQ_START: begin
                  send_index <= '0; bit_index <= '0; tick_count <= '0;
                  sending <= (active != '0);
                  state <= S_FETCH;
                end
                default: begin
                  if (req.req_type != slfs_pkg::REQ_SCALE && req.amount > 16'd255) begin
                    rej <= 1'b1;
                    state <= S_FETCH;
                  end else if (active == '0) state <= S_FETCH;
                  else state <= S_RD;
                end
              endcase
            end
          end
        end
        S_MAP: begin
          // A serpentine index past the end of the store is refused as well.
          if (lin_over) rej <= 1'b1;
          if (item.req_type == slfs_pkg::REQ_READ && !rej && !lin_over) state <= S_RDW;
          else state <= S_FETCH;
        end
        S_RDW: begin
          rd_word <= rdata;
          state <= S_FETCH;
        end
        S_RD: state <= S_OPW;
        S_OPW: begin
          addr <= addr + 1'b1;
          if (addr + 1'b1 >= active) state <= S_FETCH;
          else state <= S_RD;
        end
        S_FETCH: state <= S_DONE;
        S_DONE: begin
          if (done_go) begin
            res.line_level <= sending && (tick_count < high);
            res.busy_res <= sending;
            res.read_green <= rd_word[23:16];
            res.read_red <= rd_word[15:8];
            res.read_blue <= rd_word[7:0];
            res.not_black <= rd_word != 24'd0;
            res.rejected <= rej;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/slfs_checker.sv @@
// Port-level checker for the LED frame serializer, bound to the top level.
`default_nettype none
module slfs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           res_valid,
  input wire logic           res_stall,
  input wire slfs_pkg::out_t res
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res)) else $error("result dropped");
  a_line: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.line_level |-> res.busy_res) else $error("line high while idle");
  a_acc: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall) else $error("second item taken at once");
  a_rd: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.rejected |-> !res.not_black) else $error("rejected item read data");
endmodule

bind serpentine_led_frame_serializer_unit slfs_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .res_valid(res_valid), .res_stall(res_stall), .res(res)
);
`default_nettype wire
